FILE: rtl/cps_pkg.sv
// Shared types, constants and the sine/cosine tables of the polar sampler.
package cps_pkg;

    localparam int IMAGE_WIDTH  = 128;
    localparam int IMAGE_HEIGHT = 128;
    localparam int ANGLE_BINS   = 128;
    localparam int RADIUS_BINS  = 96;

    // field widths of the stream items
    localparam int COL_W    = 7;
    localparam int ROW_W    = 7;
    localparam int PIXEL_W  = 8;
    localparam int ANGLE_W  = 7;
    localparam int RADIUS_W = 7;
    localparam int OFFS_W   = 8;

    localparam int ANGLE_CODES = 2 ** ANGLE_W;
    localparam int ADDR_W      = $clog2(IMAGE_WIDTH * IMAGE_HEIGHT);
    localparam int DIM_W       = 11;
    localparam int TRIG_W      = 16;
    localparam int FRAC_W      = 15;
    localparam int PROD_W      = RADIUS_W + 1 + TRIG_W;
    // |r*trig| < 2^22, dimension*2^14 <= 2^24, offset*2^15 <= 2^22
    localparam int COORD_W     = 27;
    localparam int IDX_W       = COORD_W - FRAC_W;

    localparam int PHASE_BITS   = 24;
    localparam int QUARTER_BITS = 22;

    localparam logic [63:0] C1 = 64'd1686629713;
    localparam logic [63:0] C3 = 64'd693598668;
    localparam logic [63:0] C5 = 64'd85569306;
    localparam logic [63:0] C7 = 64'd5026991;
    localparam logic [63:0] C9 = 64'd172271;

    localparam logic [0:0] OP_WRITE  = 1'b0;
    localparam logic [0:0] OP_SAMPLE = 1'b1;

    typedef logic signed [TRIG_W-1:0] t_trig_rom [ANGLE_CODES];

    // one queue entry: a memory write or a pixel read
    typedef struct packed {
        logic                is_read;
        logic                in_range;
        logic [ADDR_W-1:0]   addr;
        logic [PIXEL_W-1:0]  wdata;
    } t_cmd;

    function automatic logic [63:0] f_quarter_sine(input logic [63:0] x);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] q;
        u   = x << 8;
        u2  = (u * u) >> 30;
        acc = C7 - ((C9 * u2) >> 30);
        acc = C5 - ((acc * u2) >> 30);
        acc = C3 - ((acc * u2) >> 30);
        acc = C1 - ((acc * u2) >> 30);
        s   = (u * acc) >> 30;
        q   = (s + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q;
    endfunction

    function automatic logic signed [TRIG_W-1:0] f_phase_sine(input logic [63:0] p);
        logic [63:0] quarter;
        logic [63:0] quad;
        logic [63:0] x;
        logic [63:0] v;
        quarter = 64'd1 << QUARTER_BITS;
        quad    = (p >> QUARTER_BITS) & 64'd3;
        x       = p & (quarter - 64'd1);
        v       = quad[0] ? f_quarter_sine(quarter - x) : f_quarter_sine(x);
        if (quad[1]) begin
            v = -v;
        end
        return TRIG_W'(v);
    endfunction

    // table over every angle code; codes past the bin count wrap around
    function automatic t_trig_rom f_build_rom(input logic cosine);
        t_trig_rom   rom;
        logic [63:0] idx;
        logic [63:0] ph;
        logic [63:0] p;
        logic [63:0] mask;
        mask = (64'd1 << PHASE_BITS) - 64'd1;
        for (int i = 0; i < ANGLE_CODES; i++) begin
            idx = 64'(i % ANGLE_BINS);
            ph  = ((idx << PHASE_BITS) + 64'(ANGLE_BINS / 2)) / 64'(ANGLE_BINS);
            p   = (ph + (64'd1 << (PHASE_BITS - 1))) & mask;
            if (cosine) begin
                p = (p + (64'd1 << QUARTER_BITS)) & mask;
            end
            rom[i] = f_phase_sine(p);
        end
        return rom;
    endfunction

    localparam t_trig_rom SIN_ROM = f_build_rom(1'b0);
    localparam t_trig_rom COS_ROM = f_build_rom(1'b1);

endpackage

FILE: rtl/cps_front.sv
// Front end: accepts items, maps polar cells to image addresses, issues commands.
module cps_front
    import cps_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_op,
    input  logic [COL_W-1:0]           i_column,
    input  logic [ROW_W-1:0]           i_row,
    input  logic [PIXEL_W-1:0]         i_pixel,
    input  logic [ANGLE_W-1:0]         i_angle_index,
    input  logic [RADIUS_W-1:0]        i_radius,
    input  logic signed [OFFS_W-1:0]   i_center_dx,
    input  logic signed [OFFS_W-1:0]   i_center_dy,
    output logic                       o_push,
    output t_cmd                       o_cmd,
    input  logic                       i_full
);

    localparam logic signed [COORD_W-1:0] X_BIAS = COORD_W'(IMAGE_WIDTH * 16384);
    localparam logic signed [COORD_W-1:0] Y_BIAS = COORD_W'(IMAGE_HEIGHT * 16384);
    localparam logic signed [COORD_W-1:0] NEG_ONE = -COORD_W'(32768);

    // stage 1: fields and table lookups
    logic                       r_v1;
    logic                       r1_op;
    logic [COL_W-1:0]           r1_column;
    logic [ROW_W-1:0]           r1_row;
    logic [PIXEL_W-1:0]         r1_pixel;
    logic [RADIUS_W-1:0]        r1_radius;
    logic signed [OFFS_W-1:0]   r1_dx;
    logic signed [OFFS_W-1:0]   r1_dy;
    logic signed [TRIG_W-1:0]   r1_sin;
    logic signed [TRIG_W-1:0]   r1_cos;

    // stage 2: products and write address
    logic                       r_v2;
    logic                       r2_op;
    logic                       r2_wok;
    logic [ADDR_W-1:0]          r2_waddr;
    logic [PIXEL_W-1:0]         r2_pixel;
    logic signed [OFFS_W-1:0]   r2_dx;
    logic signed [OFFS_W-1:0]   r2_dy;
    logic signed [PROD_W-1:0]   r2_px;
    logic signed [PROD_W-1:0]   r2_py;

    logic                       w_en;
    logic                       w_need;
    logic signed [COORD_W-1:0]  w_xq;
    logic signed [COORD_W-1:0]  w_yq;
    logic [IDX_W-1:0]           w_xi;
    logic [IDX_W-1:0]           w_yi;
    logic                       w_in;
    logic [ADDR_W-1:0]          w_raddr;
    logic [ADDR_W-1:0]          n_waddr;
    logic                       n_wok;

    assign w_need  = (r2_op == OP_SAMPLE) || r2_wok;
    assign w_en    = !(r_v2 && w_need && i_full);
    assign o_ready = w_en;
    assign o_push  = r_v2 && w_need && !i_full;

    assign n_wok   = (DIM_W'(r1_column) < DIM_W'(IMAGE_WIDTH))
                  && (DIM_W'(r1_row) < DIM_W'(IMAGE_HEIGHT));
    assign n_waddr = ADDR_W'(ADDR_W'(r1_row) * ADDR_W'(IMAGE_WIDTH)) + ADDR_W'(r1_column);

    always_comb begin
        w_xq = COORD_W'(r2_px) + X_BIAS + (COORD_W'(r2_dx) <<< FRAC_W);
        w_yq = COORD_W'(r2_py) + Y_BIAS + (COORD_W'(r2_dy) <<< FRAC_W);
        // a coordinate in (-1, 0) truncates to column or row zero
        w_xi = w_xq[COORD_W-1] ? '0 : w_xq[COORD_W-1:FRAC_W];
        w_yi = w_yq[COORD_W-1] ? '0 : w_yq[COORD_W-1:FRAC_W];
        w_in = (w_xq > NEG_ONE) && (w_yq > NEG_ONE)
            && (w_xi < IDX_W'(IMAGE_WIDTH)) && (w_yi < IDX_W'(IMAGE_HEIGHT));
        w_raddr = ADDR_W'(ADDR_W'(w_yi) * ADDR_W'(IMAGE_WIDTH)) + ADDR_W'(w_xi);

        o_cmd.is_read  = (r2_op == OP_SAMPLE);
        o_cmd.in_range = w_in;
        o_cmd.addr     = (r2_op == OP_SAMPLE) ? w_raddr : r2_waddr;
        o_cmd.wdata    = r2_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_op     <= i_op;
            r1_column <= i_column;
            r1_row    <= i_row;
            r1_pixel  <= i_pixel;
            r1_radius <= i_radius;
            r1_dx     <= i_center_dx;
            r1_dy     <= i_center_dy;
            r1_sin    <= SIN_ROM[i_angle_index];
            r1_cos    <= COS_ROM[i_angle_index];

            r2_op     <= r1_op;
            r2_wok    <= n_wok;
            r2_waddr  <= n_waddr;
            r2_pixel  <= r1_pixel;
            r2_dx     <= r1_dx;
            r2_dy     <= r1_dy;
            r2_px     <= $signed({1'b0, r1_radius}) * r1_sin;
            r2_py     <= $signed({1'b0, r1_radius}) * r1_cos;
        end
    end

endmodule

FILE: rtl/cps_fifo.sv
// Short command queue between the front end and the memory back end.
module cps_fifo
    import cps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_cmd  o_cmd
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_cmd              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W:0]    r_count;

    assign o_full  = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/cps_back.sv
// Back end: image memory, registered read and the result output stage.
module cps_back
    import cps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [PIXEL_W-1:0]  o_pixel,
    output logic                o_in_range
);

    localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;

    logic [PIXEL_W-1:0]  r_mem [DEPTH];
    logic [PIXEL_W-1:0]  r_rdata;
    logic                r_mv;
    logic                r_mrange;
    logic                r_out_v;
    logic [PIXEL_W-1:0]  r_out_pixel;
    logic                r_out_range;

    logic                w_out_free;
    logic                w_adv;

    assign w_out_free = !r_out_v || i_ready;
    assign w_adv      = !r_mv || w_out_free;
    assign o_pop      = w_adv && i_valid;

    assign o_valid    = r_out_v;
    assign o_pixel    = r_out_pixel;
    assign o_in_range = r_out_range;

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_cmd.is_read) begin
            r_mem[i_cmd.addr] <= i_cmd.wdata;
        end
        // hold read data while the output stage is stalled
        if (o_pop && i_cmd.is_read) begin
            r_rdata  <= r_mem[i_cmd.addr];
            r_mrange <= i_cmd.in_range;
        end
        if (w_out_free) begin
            r_out_pixel <= r_mrange ? r_rdata : '0;
            r_out_range <= r_mrange;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_adv) begin
                r_mv <= o_pop && i_cmd.is_read;
            end
            if (w_out_free) begin
                r_out_v <= r_mv;
            end
        end
    end

endmodule

FILE: rtl/cartesian_to_polar_sampler_top.sv
// Top level of the cartesian-to-polar nearest-neighbor sampler.
// The block stores a 128x128 8-bit image and takes one item per clock unless the
// command queue is full: a write item (tuser = 0) stores a pixel, a sample item
// (tuser = 1) returns the pixel under a polar cell around a shifted image middle,
// or 0 with in_range low when the cell falls outside the image. Writes past the
// image are dropped and give no result. The rate is set by the single-port image
// memory, one access per cycle at most; a sample result passes two front stages,
// the command queue, the registered memory read and the output register, the
// first of them loaded at the accepting edge.
// Results keep item order and a sample sees every earlier write.
module cartesian_to_polar_sampler_top
    import cps_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [6:0] column, [13:7] row, [21:14] pixel, [28:22] angle_index,
    // [35:29] radius, [43:36] center_dx, [51:44] center_dy, [55:52] zero
    input  logic [55:0]  s_axis_tdata,
    // [0] operation
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] polar_pixel
    output logic [7:0]   m_axis_tdata,
    // [0] in_range
    output logic [0:0]   m_axis_tuser
);

    logic  w_push;
    t_cmd  w_push_cmd;
    logic  w_full;
    logic  w_pop;
    logic  w_q_valid;
    t_cmd  w_q_cmd;

    cps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_op          (s_axis_tuser[0]),
        .i_column      (s_axis_tdata[6:0]),
        .i_row         (s_axis_tdata[13:7]),
        .i_pixel       (s_axis_tdata[21:14]),
        .i_angle_index (s_axis_tdata[28:22]),
        .i_radius      (s_axis_tdata[35:29]),
        .i_center_dx   (s_axis_tdata[43:36]),
        .i_center_dy   (s_axis_tdata[51:44]),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd),
        .i_full        (w_full)
    );

    cps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    cps_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_cmd      (w_q_cmd),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_pixel    (m_axis_tdata),
        .o_in_range (m_axis_tuser[0])
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command queue written while full");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_full)
        else $error("input stalled with room in the queue");

    a_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("out-of-image result carries a nonzero pixel");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("command popped from an empty queue");
`endif

endmodule

FILE: dv/tb_cartesian_to_polar_sampler_top.sv
// Self-checking testbench for the cartesian-to-polar sampler: directed table, then random items.
module tb_cartesian_to_polar_sampler_top;
    import cps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  PIXELS        = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int  RANDOM_ITEMS  = 1700;
    localparam int  MAX_GAP       = 18;
    localparam int  TAIL_CYCLES   = 20;
    localparam bit  PREDICTED     = 1'b0;
    localparam bit  TYPED         = 1'b1;

    typedef struct packed {
        logic [0:0]          op;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [PIXEL_W-1:0]  pix;
        logic [ANGLE_W-1:0]  ang;
        logic [RADIUS_W-1:0] rad;
        logic signed [7:0]   dx;
        logic signed [7:0]   dy;
    } sampler_req_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pix;
        logic               in_range;
    } polar_result_t;

    typedef struct packed {
        sampler_req_t  req;
        logic          typed;
        polar_result_t want;
    } stim_row_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    polar_result_t polar_expect_q [$];
    stim_row_t     stim_table [$];
    logic [7:0]    image_copy [PIXELS];
    bit            written_map [PIXELS];
    bit            no_idle;
    int            errors;
    polar_result_t want_res;

    cartesian_to_polar_sampler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // sin(pi/2 * x / 2^22) in Q15, polynomial in unsigned Q2.30 with truncated products
    function automatic logic [63:0] quarter_wave(input logic [63:0] x);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] acc;
        logic [63:0] q;
        u   = x << 8;
        u2  = (u * u) >> 30;
        acc = C7 - ((C9 * u2) >> 30);
        acc = C5 - ((acc * u2) >> 30);
        acc = C3 - ((acc * u2) >> 30);
        acc = C1 - ((acc * u2) >> 30);
        q   = (((u * acc) >> 30) + 64'd16384) >> 15;
        return (q > 64'd32767) ? 64'd32767 : q;
    endfunction

    function automatic logic signed [15:0] sine_of_phase(input logic [PHASE_BITS-1:0] p);
        logic [63:0] mag;
        logic [63:0] frac;
        frac = 64'(p[QUARTER_BITS-1:0]);
        mag  = p[QUARTER_BITS] ? quarter_wave((64'd1 << QUARTER_BITS) - frac)
                               : quarter_wave(frac);
        return p[QUARTER_BITS+1] ? -16'(mag) : 16'(mag);
    endfunction

    // source pixel coordinate of a polar cell, truncated toward zero
    function automatic void polar_source(input sampler_req_t req, output longint sx,
                                         output longint sy);
        logic [63:0]            bin;
        logic [63:0]            ph;
        logic [PHASE_BITS-1:0]  p;
        longint                 s;
        longint                 c;
        longint                 xq;
        longint                 yq;
        bin = 64'(req.ang) % 64'(ANGLE_BINS);
        ph  = ((bin << PHASE_BITS) + 64'(ANGLE_BINS / 2)) / 64'(ANGLE_BINS);
        p   = PHASE_BITS'(ph + (64'd1 << (PHASE_BITS - 1)));
        s   = longint'(sine_of_phase(p));
        c   = longint'(sine_of_phase(p + (PHASE_BITS'(1) << QUARTER_BITS)));
        xq  = longint'(req.rad) * s + longint'(IMAGE_WIDTH) * 16384
            + longint'(req.dx) * 32768;
        yq  = longint'(req.rad) * c + longint'(IMAGE_HEIGHT) * 16384
            + longint'(req.dy) * 32768;
        sx  = xq / 32768;
        sy  = yq / 32768;
    endfunction

    function automatic bit on_image(input longint sx, input longint sy);
        return sx >= 0 && sx < IMAGE_WIDTH && sy >= 0 && sy < IMAGE_HEIGHT;
    endfunction

    function automatic sampler_req_t random_req();
        sampler_req_t req;
        req.op  = 1'($urandom_range(0, 1));
        req.col = COL_W'($urandom_range(0, 127));
        req.row = ROW_W'($urandom_range(0, 127));
        req.pix = PIXEL_W'($urandom_range(0, 255));
        req.ang = ANGLE_W'($urandom_range(0, 127));
        req.rad = RADIUS_W'($urandom_range(0, 127));
        req.dx  = 8'($urandom_range(0, 255));
        req.dy  = 8'($urandom_range(0, 255));
        return req;
    endfunction

    // update the image copy and queue the pixel a sample should return
    task automatic predict_polar(input sampler_req_t req);
        longint        sx;
        longint        sy;
        polar_result_t res;
        if (req.op == OP_WRITE) begin
            image_copy[int'(req.row) * IMAGE_WIDTH + int'(req.col)] = req.pix;
        end else begin
            polar_source(req, sx, sy);
            if (on_image(sx, sy)) begin
                res.pix      = image_copy[int'(sy) * IMAGE_WIDTH + int'(sx)];
                res.in_range = 1'b1;
            end else begin
                res = '0;
            end
            polar_expect_q.push_back(res);
        end
    endtask

    // task is entered and left at a falling edge
    task automatic send_item(input sampler_req_t req, input bit typed,
                             input polar_result_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        if (req.op == OP_WRITE) begin
            written_map[int'(req.row) * IMAGE_WIDTH + int'(req.col)] = 1'b1;
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'b0, req.dy, req.dx, req.rad, req.ang, req.pix, req.row, req.col};
        s_axis_tuser  = req.op;
        do @(posedge i_clk); while (!s_axis_tready);
        if (typed) begin
            polar_expect_q.push_back(want);
        end else begin
            predict_polar(req);
        end
        @(negedge i_clk);
    endtask

    // load the source pixel first when a sample would land on an unwritten one
    task automatic issue(input sampler_req_t req, input bit typed, input polar_result_t want);
        longint       sx;
        longint       sy;
        sampler_req_t fill;
        if (req.op == OP_SAMPLE) begin
            polar_source(req, sx, sy);
            if (on_image(sx, sy) && !written_map[int'(sy) * IMAGE_WIDTH + int'(sx)]) begin
                fill     = random_req();
                fill.op  = OP_WRITE;
                fill.col = COL_W'(sx);
                fill.row = ROW_W'(sy);
                send_item(fill, PREDICTED, '0);
            end
        end
        send_item(req, typed, want);
    endtask

    task automatic drain_pending();
        s_axis_tvalid = 1'b0;
        while (polar_expect_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic [0:0] op, input int col, input int row, input int pix,
                           input int ang, input int rad, input int dx, input int dy,
                           input bit typed, input int want_pix, input logic want_in);
        stim_row_t r;
        r.req           = '{op, COL_W'(col), ROW_W'(row), PIXEL_W'(pix), ANGLE_W'(ang),
                            RADIUS_W'(rad), 8'(dx), 8'(dy)};
        r.typed         = typed;
        r.want.pix      = PIXEL_W'(want_pix);
        r.want.in_range = want_in;
        stim_table.push_back(r);
    endtask

    // receiver: stall at random before each result, except while no_idle is set
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (polar_expect_q.size() == 0) begin
                $display("%0t: unexpected result pixel %0h in_range %0b", $time,
                         m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want_res = polar_expect_q.pop_front();
                if (m_axis_tdata !== want_res.pix) begin
                    $display("%0t: polar_pixel expected %0h actual %0h", $time,
                             want_res.pix, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser[0] !== want_res.in_range) begin
                    $display("%0t: in_range expected %0b actual %0b", $time,
                             want_res.in_range, m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("cartesian_to_polar_sampler_top regression: fail");
        $finish;
    end

    initial begin
        sampler_req_t req;
        int           d;
        errors        = 0;
        no_idle       = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_WRITE;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        //      op         col  row  pix   ang  rad  dx    dy    check      pix   in
        add_row(OP_WRITE,   64,  64, 'hA5,   0,   0,    0,    0, PREDICTED, 0,    0);
        add_row(OP_SAMPLE,   0,   0,    0,  64,   0,    0,    0, TYPED,     'hA5, 1);
        add_row(OP_WRITE,    0,   0, 'h00,   0,   0,    0,    0, PREDICTED, 0,    0);
        add_row(OP_WRITE,  127, 127, 'hFF,   0,   0,    0,    0, PREDICTED, 0,    0);
        add_row(OP_WRITE,    0, 127, 'h3C,   0,   0,    0,    0, PREDICTED, 0,    0);
        add_row(OP_WRITE,  127,   0, 'hC3,   0,   0,    0,    0, PREDICTED, 0,    0);
        // image corners at radius zero
        add_row(OP_SAMPLE,   0,   0,    0,  64,   0,  -64,  -64, TYPED,     'h00, 1);
        add_row(OP_SAMPLE,   0,   0,    0,  64,   0,   63,   63, TYPED,     'hFF, 1);
        add_row(OP_SAMPLE,   0,   0,    0,  64,   0,  -64,   63, TYPED,     'h3C, 1);
        add_row(OP_SAMPLE,   0,   0,    0,  64,   0,   63,  -64, TYPED,     'hC3, 1);
        // one pixel past the left and right edges, then the offset extremes
        add_row(OP_SAMPLE,   0,   0,    0,  64,   0,  -65,    0, TYPED,     0,    0);
        add_row(OP_SAMPLE,   0,   0,    0,  64,   0,   64,    0, TYPED,     0,    0);
        add_row(OP_SAMPLE,   0,   0,    0,  64,   0,    0, -128, TYPED,     0,    0);
        add_row(OP_SAMPLE,   0,   0,    0,  64,   0,  127,  127, TYPED,     0,    0);
        add_row(OP_SAMPLE,   0,   0,    0, 127, 127, -128, -128, TYPED,     0,    0);
        // source just left of column zero truncates onto the image
        add_row(OP_SAMPLE,   0,   0,    0,  63,   1,  -64,  -64, PREDICTED, 0,    0);
        add_row(OP_SAMPLE,   0,   0,    0,   0,  95,    0,    0, PREDICTED, 0,    0);
        add_row(OP_SAMPLE,   0,   0,    0,  32,  40,    0,    0, PREDICTED, 0,    0);
        add_row(OP_SAMPLE,   0,   0,    0,  96, 127,    0,    0, PREDICTED, 0,    0);
        add_row(OP_SAMPLE,   0,   0,    0,  64,  63,    0,    0, PREDICTED, 0,    0);
        add_row(OP_SAMPLE,   0,   0,    0,  16, 100,   20,  -30, PREDICTED, 0,    0);
        // write with every field at its top code, sample fields ignored
        add_row(OP_WRITE,  127, 127, 'hFF, 127, 127,   -1,   -1, PREDICTED, 0,    0);
        add_row(OP_SAMPLE,   0,   0,    0,  64,   0,   63,   63, TYPED,     'hFF, 1);
        add_row(OP_SAMPLE,   0,   0,    0,  64,   0,    0,    0, TYPED,     'hA5, 1);

        @(negedge i_clk);
        foreach (stim_table[n]) begin
            issue(stim_table[n].req, stim_table[n].typed, stim_table[n].want);
        end
        drain_pending();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_ITEMS / 2) begin
                drain_pending();
            end
            req    = random_req();
            req.op = ($urandom_range(0, 9) < 4) ? OP_WRITE : OP_SAMPLE;
            // keep most samples near the middle so that they hit the image
            if ($urandom_range(0, 4) != 0) begin
                req.rad = RADIUS_W'($urandom_range(0, 70));
            end
            if ($urandom_range(0, 3) != 0) begin
                d      = int'($urandom_range(0, 80)) - 40;
                req.dx = 8'(d);
                d      = int'($urandom_range(0, 80)) - 40;
                req.dy = 8'(d);
            end
            issue(req, PREDICTED, '0);
        end
        drain_pending();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("cartesian_to_polar_sampler_top regression: pass");
        end else begin
            $display("cartesian_to_polar_sampler_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: cartesian_to_polar_sampler_top.f
rtl/cps_pkg.sv
rtl/cps_front.sv
rtl/cps_fifo.sv
rtl/cps_back.sv
rtl/cartesian_to_polar_sampler_top.sv
dv/tb_cartesian_to_polar_sampler_top.sv
